[design/ctfgs_pkg.sv]
// shared types, codes and helpers of the grid search dispatcher
`default_nettype none
package ctfgs_pkg;

	localparam int NUM_DIMS  = 4;
	localparam int COORD_W   = 16;
	localparam int NUM_SLOTS = 8;
	localparam int PACK_W    = NUM_DIMS * COORD_W;
	localparam int SLOT_W    = $clog2(NUM_SLOTS);
	localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 64;

	// request codes
	localparam logic [1:0] REQ_ASK     = 2'd0;
	localparam logic [1:0] REQ_REPORT  = 2'd1;
	localparam logic [1:0] REQ_REDO    = 2'd2;
	localparam logic [1:0] REQ_RESTART = 2'd3;

	// result status codes
	localparam logic [1:0] ST_ASSIGNED = 2'd0;
	localparam logic [1:0] ST_NONE     = 2'd1;
	localparam logic [1:0] ST_ACCEPTED = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LOWER  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_UPPER  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd3;

	// datapath operations
	typedef logic [4:0] op_t;
	localparam op_t OP_NONE        = 5'd0;
	localparam op_t OP_LATCH       = 5'd1;
	localparam op_t OP_READ        = 5'd2;
	localparam op_t OP_REDO_POP    = 5'd3;
	localparam op_t OP_REJECT      = 5'd4;
	localparam op_t OP_GIVE_REPEAT = 5'd5;
	localparam op_t OP_GIVE_ODO    = 5'd6;
	localparam op_t OP_REPORT      = 5'd7;
	localparam op_t OP_REDO_PUSH   = 5'd8;
	localparam op_t OP_RESTART     = 5'd9;
	localparam op_t OP_DIV_SUM     = 5'd10;
	localparam op_t OP_MEAN        = 5'd11;
	localparam op_t OP_DIV_SQ      = 5'd12;
	localparam op_t OP_VAR         = 5'd13;
	localparam op_t OP_KLO         = 5'd14;
	localparam op_t OP_KHI         = 5'd15;
	localparam op_t OP_CMP         = 5'd16;
	localparam op_t OP_NOPEAK      = 5'd17;
	localparam op_t OP_WRAP        = 5'd18;
	localparam op_t OP_OUT         = 5'd19;

	typedef struct packed {
		op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic       redo_nz;
		logic       blocked;
		logic       rep_nz;
		logic       odo_adv;
		logic       pending;
		logic       cnt_zero;
		logic       div_done;
	} dp_stat_t;

	// smallest power of two not below half, at least one
	function automatic logic [COORD_W-1:0] ceil_pow2(input logic [COORD_W-1:0] half);
		logic [COORD_W-1:0] x;
		x = half - 1'b1;
		x = x | (x >> 1);
		x = x | (x >> 2);
		x = x | (x >> 4);
		x = x | (x >> 8);
		if (half <= 1)
			return {{(COORD_W-1){1'b0}}, 1'b1};
		return x + 1'b1;
	endfunction

endpackage
`default_nettype wire

[design/ctfgs_if.sv]
// request and response channels of the dispatcher
`default_nettype none
interface ctfgs_req_if;
	logic              valid;
	logic              ready;
	logic [1:0]        req_type;
	logic [2:0]        slot;
	logic signed [31:0] value;
	modport source(output valid, output req_type, output slot, output value, input ready);
	modport sink(input valid, input req_type, input slot, input value, output ready);
endinterface

interface ctfgs_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [2:0]         assigned_slot;
	logic [63:0]        assigned_coords;
	logic               search_done;
	logic signed [31:0] best_value;
	logic [63:0]        best_coords;
	logic [31:0]        reports_count;
	modport source(output valid, output status, output assigned_slot, output assigned_coords,
		output search_done, output best_value, output best_coords, output reports_count,
		input ready);
	modport sink(input valid, input status, input assigned_slot, input assigned_coords,
		input search_done, input best_value, input best_coords, input reports_count,
		output ready);
endinterface
`default_nettype wire

[design/ctfgs_div.sv]
// iterative unsigned 64 by 32 divider, one quotient bit per cycle
`default_nettype none
module ctfgs_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic [63:0] quotient,
	output logic        done
);
	logic        busy_q;
	logic        done_q;
	logic [6:0]  cnt_q;
	logic [31:0] rem_q;
	logic [63:0] quo_q;
	logic [32:0] shifted;
	logic [32:0] diff;

	assign shifted = {rem_q, quo_q[63]};
	assign diff    = shifted - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted[31:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;
endmodule
`default_nettype wire

[design/ctfgs_datapath.sv]
// state, stacks, statistics and peak arithmetic of the dispatcher
`default_nettype none
module ctfgs_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ctfgs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ctfgs_pkg::CFG_W-1:0]         cfg_data,
	input  logic [1:0]                          in_req_type,
	input  logic [2:0]                          in_slot,
	input  logic signed [31:0]                  in_value,
	input  ctfgs_pkg::dp_cmd_t                  cmd,
	output ctfgs_pkg::dp_stat_t                 stat,
	output logic [1:0]                          status,
	output logic [2:0]                          assigned_slot,
	output logic [ctfgs_pkg::PACK_W-1:0]        assigned_coords,
	output logic                                search_done,
	output logic signed [31:0]                  best_value,
	output logic [ctfgs_pkg::PACK_W-1:0]        best_coords,
	output logic [31:0]                         reports_count
);
	localparam int CW = ctfgs_pkg::COORD_W;
	localparam int ND = ctfgs_pkg::NUM_DIMS;
	localparam int NS = ctfgs_pkg::NUM_SLOTS;
	localparam int SW = ctfgs_pkg::SLOT_W;
	localparam int KW = ctfgs_pkg::CNT_W;
	localparam int PW = ctfgs_pkg::PACK_W;

	// configuration
	logic [PW-1:0] lower_q, upper_q;
	logic [3:0]    rep_cnt_q;
	logic [7:0]    thr_q;

	// latched item
	logic [1:0]         req_q;
	logic [2:0]         slot_q;
	logic signed [31:0] value_q;

	// search state
	logic [CW-1:0] cur_q    [ND];
	logic [CW-1:0] wstart_q [ND];
	logic [CW-1:0] wend_q   [ND];
	logic [CW-1:0] step_q   [ND];
	logic [SW-1:0] free_stk_q [NS];
	logic [KW-1:0] free_cnt_q;
	logic [SW-1:0] redo_stk_q [NS];
	logic [KW-1:0] redo_cnt_q;
	logic [3:0]    rep_left_q;
	logic signed [31:0] best_q;
	logic [PW-1:0] best_pt_q;
	logic [31:0]   issued_q, reported_q, pcount_q;
	logic signed [63:0] psum_q;
	logic [63:0]   psq_q;
	logic          fin_q;

	// slot point store
	logic [PW-1:0] slot_mem [NS];
	logic [PW-1:0] rdata_q;

	// peak test temporaries
	logic [47:0]        sq_s1;
	logic signed [31:0] mean_q;
	logic [47:0]        m2_q;
	logic signed [32:0] d_q;
	logic [63:0]        var_q, dd_q;
	logic [23:0]        k_q;
	logic [55:0]        plo_q, phi_q;
	logic               peak_q;

	// pending result
	logic [1:0]    res_status_q;
	logic [2:0]    res_slot_q;
	logic [PW-1:0] res_coords_q;

	// output register
	logic [1:0]         o_status_q;
	logic [2:0]         o_slot_q;
	logic [PW-1:0]      o_coords_q;
	logic               o_done_q;
	logic signed [31:0] o_best_q;
	logic [PW-1:0]      o_best_pt_q;
	logic [31:0]        o_reports_q;

	// combinational helpers
	logic [KW-1:0] free_m1, redo_m1;
	logic [SW-1:0] free_top, redo_top, free_push, rd_addr;
	logic [CW:0]   odo_sum [ND];
	logic [ND-1:0] odo_ok;
	logic [CW-1:0] odo_next [ND];
	logic          odo_found;
	logic [CW+1:0] zb_raw [ND];
	logic [CW+1:0] ze_raw [ND];
	logic [CW-1:0] zb [ND];
	logic [CW-1:0] ze [ND];
	logic [CW-1:0] wrap_cur [ND];
	logic [CW-1:0] half_step [ND];
	logic [ND-1:0] can_halve;
	logic [CW-1:0] rs_step [ND];
	logic [CW-1:0] rs_half [ND];
	logic [PW-1:0] cur_pack, odo_pack, wrap_pack, give_pack;
	logic [SW-1:0] give_slot;
	logic [64:0]   sum_ext;
	logic [63:0]   sum_sat;
	logic [64:0]   sq_ext;
	logic [63:0]   sq_sat;
	logic [31:0]   abs_v, abs_mean;
	logic [63:0]   v_sq, mean_sq;
	logic [63:0]   sum_mag, div_dividend, div_quo;
	logic          div_start, div_done;
	logic [31:0]   mean_new;
	logic [31:0]   k_mul_a;
	logic [55:0]   k_mul;
	logic [87:0]   vk_prod;
	logic          d_pos;
	logic          is_give;

	assign free_m1   = free_cnt_q - 1'b1;
	assign redo_m1   = redo_cnt_q - 1'b1;
	assign free_top  = free_m1[SW-1:0];
	assign redo_top  = redo_m1[SW-1:0];
	assign free_push = free_cnt_q[SW-1:0];
	assign rd_addr   = (req_q == ctfgs_pkg::REQ_REPORT) ? slot_q[SW-1:0] : redo_stk_q[redo_top];
	assign give_slot = free_stk_q[free_top];

	// odometer, dimension 0 fastest
	always_comb begin
		odo_found = 1'b0;
		for (int i = 0; i < ND; i++) begin
			odo_sum[i] = {1'b0, cur_q[i]} + {1'b0, step_q[i]};
			odo_ok[i]  = odo_sum[i] < {1'b0, wend_q[i]};
		end
		for (int i = 0; i < ND; i++) begin
			if (odo_found) begin
				odo_next[i] = cur_q[i];
			end else if (odo_ok[i]) begin
				odo_next[i] = odo_sum[i][CW-1:0];
				odo_found   = 1'b1;
			end else begin
				odo_next[i] = wstart_q[i];
			end
		end
	end

	// zoom window, step halving and restart steps
	always_comb begin
		for (int i = 0; i < ND; i++) begin
			zb_raw[i] = {2'b00, best_pt_q[i*CW +: CW]} - {2'b00, step_q[i]};
			ze_raw[i] = {2'b00, best_pt_q[i*CW +: CW]} + {2'b00, step_q[i]} + 1'b1;
			zb[i] = ($signed(zb_raw[i]) < $signed({2'b00, lower_q[i*CW +: CW]})) ?
				lower_q[i*CW +: CW] : zb_raw[i][CW-1:0];
			ze[i] = (ze_raw[i] > {2'b00, upper_q[i*CW +: CW]}) ?
				upper_q[i*CW +: CW] : ze_raw[i][CW-1:0];
			wrap_cur[i]  = peak_q ? zb[i] : wstart_q[i];
			can_halve[i] = step_q[i] > 1;
			half_step[i] = can_halve[i] ? (step_q[i] >> 1) : step_q[i];
			rs_half[i] = (upper_q[i*CW +: CW] > lower_q[i*CW +: CW]) ?
				((upper_q[i*CW +: CW] - lower_q[i*CW +: CW]) >> 1) : '0;
			rs_step[i] = ctfgs_pkg::ceil_pow2(rs_half[i]);
			cur_pack[i*CW +: CW]  = cur_q[i];
			odo_pack[i*CW +: CW]  = odo_next[i];
			wrap_pack[i*CW +: CW] = wrap_cur[i];
		end
	end

	always_comb begin
		case (cmd.op)
			ctfgs_pkg::OP_GIVE_REPEAT: give_pack = cur_pack;
			ctfgs_pkg::OP_GIVE_ODO:    give_pack = odo_pack;
			default:                   give_pack = wrap_pack;
		endcase
	end

	assign is_give = (cmd.op == ctfgs_pkg::OP_GIVE_REPEAT) || (cmd.op == ctfgs_pkg::OP_GIVE_ODO)
		|| ((cmd.op == ctfgs_pkg::OP_WRAP) && (|can_halve));

	// saturating statistics
	assign sum_ext = {psum_q[63], psum_q} + {{33{value_q[31]}}, value_q};
	assign sum_sat = (sum_ext[64] != sum_ext[63]) ?
		(sum_ext[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : sum_ext[63:0];
	assign sq_ext  = {1'b0, psq_q} + {17'd0, sq_s1};
	assign sq_sat  = sq_ext[64] ? {64{1'b1}} : sq_ext[63:0];

	assign abs_v    = value_q[31] ? (32'd0 - value_q) : value_q;
	assign v_sq     = abs_v * abs_v;
	assign abs_mean = mean_q[31] ? (32'd0 - mean_q) : mean_q;
	assign mean_sq  = abs_mean * abs_mean;

	// mean and mean square through the shared divider
	assign sum_mag      = psum_q[63] ? (64'd0 - psum_q) : psum_q;
	assign div_start    = (cmd.op == ctfgs_pkg::OP_DIV_SUM) || (cmd.op == ctfgs_pkg::OP_DIV_SQ);
	assign div_dividend = (cmd.op == ctfgs_pkg::OP_DIV_SUM) ? sum_mag : psq_q;

	ctfgs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (pcount_q),
		.quotient (div_quo),
		.done     (div_done)
	);

	always_comb begin
		if (!psum_q[63])
			mean_new = (div_quo > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : div_quo[31:0];
		else
			mean_new = (div_quo > 64'h0000_0000_8000_0000) ? 32'h8000_0000 :
				(32'd0 - div_quo[31:0]);
	end

	// var times k in two 32 by 24 partial products
	assign k_mul_a = (cmd.op == ctfgs_pkg::OP_KHI) ? var_q[63:32] : var_q[31:0];
	assign k_mul   = k_mul_a * k_q;
	assign vk_prod = {phi_q, 32'd0} + {32'd0, plo_q};
	assign d_pos   = !d_q[32] && (d_q != '0);

	assign stat.req_type = req_q;
	assign stat.redo_nz  = redo_cnt_q != '0;
	assign stat.blocked  = fin_q || (free_cnt_q == '0);
	assign stat.rep_nz   = rep_left_q != '0;
	assign stat.odo_adv  = |odo_ok;
	assign stat.pending  = reported_q < issued_q;
	assign stat.cnt_zero = pcount_q == '0;
	assign stat.div_done = div_done;

	// state with reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q    <= '0;
			upper_q    <= '1;
			rep_cnt_q  <= 4'd1;
			thr_q      <= 8'd8;
			for (int i = 0; i < ND; i++) begin
				cur_q[i]    <= '0;
				wstart_q[i] <= '0;
				wend_q[i]   <= '0;
				step_q[i]   <= {{(CW-1){1'b0}}, 1'b1};
			end
			for (int k = 0; k < NS; k++)
				free_stk_q[k] <= SW'(k);
			free_cnt_q <= KW'(NS);
			redo_cnt_q <= '0;
			rep_left_q <= 4'd1;
			best_q     <= 32'sh8000_0000;
			best_pt_q  <= '0;
			issued_q   <= '0;
			reported_q <= '0;
			pcount_q   <= '0;
			psum_q     <= '0;
			psq_q      <= '0;
			fin_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					ctfgs_pkg::CFG_LOWER:  lower_q   <= cfg_data[PW-1:0];
					ctfgs_pkg::CFG_UPPER:  upper_q   <= cfg_data[PW-1:0];
					ctfgs_pkg::CFG_REPEAT: rep_cnt_q <= cfg_data[3:0];
					ctfgs_pkg::CFG_THRESH: thr_q     <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (is_give) begin
				if (issued_q != '1)
					issued_q <= issued_q + 1'b1;
				free_cnt_q <= free_m1;
			end
			case (cmd.op)
				ctfgs_pkg::OP_REDO_POP: redo_cnt_q <= redo_m1;
				ctfgs_pkg::OP_GIVE_REPEAT: rep_left_q <= rep_left_q - 1'b1;
				ctfgs_pkg::OP_GIVE_ODO: begin
					for (int i = 0; i < ND; i++)
						cur_q[i] <= odo_next[i];
					rep_left_q <= rep_cnt_q;
				end
				ctfgs_pkg::OP_REPORT: begin
					if (reported_q != '1)
						reported_q <= reported_q + 1'b1;
					if (pcount_q != '1)
						pcount_q <= pcount_q + 1'b1;
					psum_q <= sum_sat;
					psq_q  <= sq_sat;
					if (value_q > best_q) begin
						best_q    <= value_q;
						best_pt_q <= rdata_q;
					end
					if (free_cnt_q < KW'(NS)) begin
						free_stk_q[free_push] <= slot_q[SW-1:0];
						free_cnt_q <= free_cnt_q + 1'b1;
					end
				end
				ctfgs_pkg::OP_REDO_PUSH: begin
					if (redo_cnt_q < KW'(NS))
						redo_cnt_q <= redo_cnt_q + 1'b1;
				end
				ctfgs_pkg::OP_RESTART: begin
					for (int i = 0; i < ND; i++) begin
						wstart_q[i] <= lower_q[i*CW +: CW];
						wend_q[i]   <= upper_q[i*CW +: CW];
						step_q[i]   <= rs_step[i];
						cur_q[i]    <= lower_q[i*CW +: CW];
					end
					for (int k = 0; k < NS; k++)
						free_stk_q[k] <= SW'(k);
					free_cnt_q <= KW'(NS);
					redo_cnt_q <= '0;
					rep_left_q <= rep_cnt_q;
					best_q     <= 32'sh8000_0000;
					best_pt_q  <= '0;
					issued_q   <= '0;
					reported_q <= '0;
					fin_q      <= 1'b0;
					pcount_q   <= '0;
					psum_q     <= '0;
					psq_q      <= '0;
				end
				ctfgs_pkg::OP_WRAP: begin
					for (int i = 0; i < ND; i++) begin
						cur_q[i]  <= wrap_cur[i];
						step_q[i] <= half_step[i];
						if (peak_q) begin
							wstart_q[i] <= zb[i];
							wend_q[i]   <= ze[i];
						end
					end
					rep_left_q <= rep_cnt_q;
					if (|can_halve) begin
						pcount_q <= '0;
						psum_q   <= '0;
						psq_q    <= '0;
					end else begin
						fin_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// redo stack holds no reset value
	always_ff @(posedge clk) begin
		if ((cmd.op == ctfgs_pkg::OP_REDO_PUSH) && (redo_cnt_q < KW'(NS)))
			redo_stk_q[redo_cnt_q[SW-1:0]] <= slot_q[SW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= 1'b0;
		end else begin
			case (cmd.op)
				ctfgs_pkg::OP_CMP:    peak_q <= d_pos && ({24'd0, dd_q} > vk_prod);
				ctfgs_pkg::OP_NOPEAK: peak_q <= 1'b0;
				default: ;
			endcase
		end
	end

	// slot point store
	always_ff @(posedge clk) begin
		if (is_give)
			slot_mem[give_slot] <= give_pack;
		if (cmd.op == ctfgs_pkg::OP_READ)
			rdata_q <= slot_mem[rd_addr];
	end

	// payload and arithmetic registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			ctfgs_pkg::OP_LATCH: begin
				req_q   <= in_req_type;
				slot_q  <= in_slot;
				value_q <= in_value;
			end
			ctfgs_pkg::OP_READ: sq_s1 <= v_sq[63:16];
			ctfgs_pkg::OP_MEAN: mean_q <= mean_new;
			ctfgs_pkg::OP_DIV_SQ: begin
				m2_q <= mean_sq[63:16];
				d_q  <= {best_q[31], best_q} - {mean_q[31], mean_q};
			end
			ctfgs_pkg::OP_VAR: begin
				var_q <= (div_quo > {16'd0, m2_q}) ? (div_quo - {16'd0, m2_q}) : 64'd0;
				dd_q  <= d_q[31:0] * d_q[31:0];
				k_q   <= {({8'd0, thr_q} * {8'd0, thr_q}), 8'd0};
			end
			ctfgs_pkg::OP_KLO: plo_q <= k_mul;
			ctfgs_pkg::OP_KHI: phi_q <= k_mul;
			default: ;
		endcase
		if (is_give) begin
			res_status_q <= ctfgs_pkg::ST_ASSIGNED;
			res_slot_q   <= 3'(give_slot);
			res_coords_q <= give_pack;
		end else begin
			case (cmd.op)
				ctfgs_pkg::OP_REDO_POP: begin
					res_status_q <= ctfgs_pkg::ST_ASSIGNED;
					res_slot_q   <= 3'(redo_stk_q[redo_top]);
					res_coords_q <= rdata_q;
				end
				ctfgs_pkg::OP_REJECT, ctfgs_pkg::OP_WRAP: begin
					res_status_q <= ctfgs_pkg::ST_NONE;
					res_slot_q   <= '0;
					res_coords_q <= '0;
				end
				ctfgs_pkg::OP_REPORT, ctfgs_pkg::OP_REDO_PUSH, ctfgs_pkg::OP_RESTART: begin
					res_status_q <= ctfgs_pkg::ST_ACCEPTED;
					res_slot_q   <= '0;
					res_coords_q <= '0;
				end
				default: ;
			endcase
		end
		if (cmd.op == ctfgs_pkg::OP_OUT) begin
			o_status_q  <= res_status_q;
			o_slot_q    <= res_slot_q;
			o_coords_q  <= res_coords_q;
			o_done_q    <= fin_q;
			o_best_q    <= best_q;
			o_best_pt_q <= best_pt_q;
			o_reports_q <= reported_q;
		end
	end

	assign status          = o_status_q;
	assign assigned_slot   = o_slot_q;
	assign assigned_coords = o_coords_q;
	assign search_done     = o_done_q;
	assign best_value      = o_best_q;
	assign best_coords     = o_best_pt_q;
	assign reports_count   = o_reports_q;

`ifndef SYNTH
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_cnt_q <= KW'(NS)) else $error("free slot count above slot total");
	a_redo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		redo_cnt_q <= KW'(NS)) else $error("redo count above slot total");
	a_give_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		is_give |-> (free_cnt_q != '0)) else $error("point given from empty free stack");
`endif
endmodule
`default_nettype wire

[design/ctfgs_ctrl.sv]
// sequencing state machine of the dispatcher
`default_nettype none
module ctfgs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	input  ctfgs_pkg::dp_stat_t stat,
	output ctfgs_pkg::dp_cmd_t  cmd
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_READ = 4'd1;
	localparam logic [3:0] S_EXEC = 4'd2;
	localparam logic [3:0] S_DIV1 = 4'd3;
	localparam logic [3:0] S_MSQ  = 4'd4;
	localparam logic [3:0] S_DIV2 = 4'd5;
	localparam logic [3:0] S_KLO  = 4'd6;
	localparam logic [3:0] S_KHI  = 4'd7;
	localparam logic [3:0] S_CMP  = 4'd8;
	localparam logic [3:0] S_WRAP = 4'd9;
	localparam logic [3:0] S_OUT  = 4'd10;

	logic [3:0] state_q, state_d;
	logic       rsp_valid_q;
	logic       load_out;

	assign req_ready = state_q == S_IDLE;
	assign load_out  = (state_q == S_OUT) && (!rsp_valid_q || rsp_ready);

	always_comb begin
		state_d = state_q;
		cmd.op  = ctfgs_pkg::OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.op  = ctfgs_pkg::OP_LATCH;
					state_d = S_READ;
				end
			end
			S_READ: begin
				cmd.op  = ctfgs_pkg::OP_READ;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_OUT;
				case (stat.req_type)
					ctfgs_pkg::REQ_RESTART: cmd.op = ctfgs_pkg::OP_RESTART;
					ctfgs_pkg::REQ_REPORT:  cmd.op = ctfgs_pkg::OP_REPORT;
					ctfgs_pkg::REQ_REDO:    cmd.op = ctfgs_pkg::OP_REDO_PUSH;
					default: begin
						if (stat.redo_nz)
							cmd.op = ctfgs_pkg::OP_REDO_POP;
						else if (stat.blocked)
							cmd.op = ctfgs_pkg::OP_REJECT;
						else if (stat.rep_nz)
							cmd.op = ctfgs_pkg::OP_GIVE_REPEAT;
						else if (stat.odo_adv)
							cmd.op = ctfgs_pkg::OP_GIVE_ODO;
						else if (stat.pending)
							cmd.op = ctfgs_pkg::OP_REJECT;
						else if (stat.cnt_zero) begin
							cmd.op  = ctfgs_pkg::OP_NOPEAK;
							state_d = S_WRAP;
						end else begin
							cmd.op  = ctfgs_pkg::OP_DIV_SUM;
							state_d = S_DIV1;
						end
					end
				endcase
			end
			S_DIV1: begin
				if (stat.div_done) begin
					cmd.op  = ctfgs_pkg::OP_MEAN;
					state_d = S_MSQ;
				end
			end
			S_MSQ: begin
				cmd.op  = ctfgs_pkg::OP_DIV_SQ;
				state_d = S_DIV2;
			end
			S_DIV2: begin
				if (stat.div_done) begin
					cmd.op  = ctfgs_pkg::OP_VAR;
					state_d = S_KLO;
				end
			end
			S_KLO: begin
				cmd.op  = ctfgs_pkg::OP_KLO;
				state_d = S_KHI;
			end
			S_KHI: begin
				cmd.op  = ctfgs_pkg::OP_KHI;
				state_d = S_CMP;
			end
			S_CMP: begin
				cmd.op  = ctfgs_pkg::OP_CMP;
				state_d = S_WRAP;
			end
			S_WRAP: begin
				cmd.op  = ctfgs_pkg::OP_WRAP;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (load_out) begin
					cmd.op  = ctfgs_pkg::OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
endmodule
`default_nettype wire

[design/coarse_to_fine_grid_search_dispatcher_top.sv]
// top level of the coarse to fine grid search dispatcher
// report, redo, restart and most asks: item latched, slot store read, operation executed,
// result loaded into the output register; an ask that ends a pass with reports also runs
// two divisions and the peak test; one item at a time, the next one accepted once the
// previous result is loaded, even while that result waits in the output register
// reset: asynchronous active low; config returns to defaults, window empty, all slots free
`default_nettype none
module coarse_to_fine_grid_search_dispatcher_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ctfgs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ctfgs_pkg::CFG_W-1:0]     cfg_data,
	ctfgs_req_if.sink                       req,
	ctfgs_rsp_if.source                     rsp
);
	// command and status between the sequencer and the datapath
	ctfgs_pkg::dp_cmd_t  cmd;
	ctfgs_pkg::dp_stat_t stat;

	// sequencer: takes one item, steps the datapath, then hands off the result
	ctfgs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath: grid cursor, slot stacks, pass statistics and the output register
	ctfgs_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_req_type     (req.req_type),
		.in_slot         (req.slot),
		.in_value        (req.value),
		.cmd             (cmd),
		.stat            (stat),
		.status          (rsp.status),
		.assigned_slot   (rsp.assigned_slot),
		.assigned_coords (rsp.assigned_coords),
		.search_done     (rsp.search_done),
		.best_value      (rsp.best_value),
		.best_coords     (rsp.best_coords),
		.reports_count   (rsp.reports_count)
	);
endmodule
`default_nettype wire
